// File: design/assert_macros.svh
// Assertion helpers used by the checker hcs_chk; clk and arst_n come from the enclosing scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: design/hcs_pkg.sv
package hcs_pkg;

	localparam int MAX_WIDTH  = 1024;
	localparam int RING_DEPTH = 2 * MAX_WIDTH + 4;
	localparam int SLOT_W     = $clog2(RING_DEPTH);
	localparam int COL_W      = $clog2(MAX_WIDTH);
	localparam int WID_W      = $clog2(MAX_WIDTH + 1);
	localparam int ROW_W      = 11;
	localparam int FILL_W     = $clog2(3 * (MAX_WIDTH + 1) + 1);

	localparam logic [1:0] REG_WIDTH  = 2'd0;
	localparam logic [1:0] REG_HEIGHT = 2'd1;
	localparam logic [1:0] REG_K      = 2'd2;
	localparam logic [1:0] REG_THRESH = 2'd3;

	// floor(x*3333/10000) and floor(x*111/1000) as multiply and shift by 24
	localparam logic [22:0] GRAY_MUL = 23'd5591847;
	localparam logic [20:0] BLUR_MUL = 21'd1862271;

	typedef logic [7:0] pix_t;
	typedef logic signed [10:0] grad_t;

	typedef struct packed {
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
	} pos_t;

	function automatic pos_t pos_adv(pos_t p, logic [WID_W-1:0] w, logic [ROW_W-1:0] h);
		pos_t n;
		n = p;
		if ((WID_W+1)'(p.col) + (WID_W+1)'(1) == {1'b0, w}) begin
			n.col = '0;
			if ({1'b0, p.row} + (ROW_W+1)'(1) == {1'b0, h}) begin
				n.row = '0;
			end else begin
				n.row = p.row + ROW_W'(1);
			end
		end else begin
			n.col = p.col + COL_W'(1);
		end
		return n;
	endfunction

	function automatic logic pos_inner(pos_t p, logic [WID_W-1:0] w, logic [ROW_W-1:0] h);
		return (p.row != '0) && ({1'b0, p.row} + (ROW_W+1)'(2) <= {1'b0, h})
			&& (p.col != '0) && ((WID_W+1)'(p.col) + (WID_W+1)'(2) <= {1'b0, w});
	endfunction

endpackage

// File: design/harris_corner_stream.sv
// A result is loaded in ST_OUT after its item has passed GWIN, BLUR, BWIN, GRAD, DWIN,
// the 9-step gradient product accumulation and the two multiply stages MUL1 and MUL2;
// ST_OUT waits while an earlier result is stalled; items are taken only in ST_IDLE.
// The result for a pixel arrives with the item 3*(W+1) beats behind it in the stream.
// Reset clears control, counters and registers to defaults; the line stores are not
// cleared, and the first 3*(W+1) items after reset or a geometry write give no result.
module harris_corner_stream import hcs_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [46:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               action,
	input  logic [7:0]         blue,
	input  logic [7:0]         green,
	input  logic [7:0]         red,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               corner_flag,
	output logic signed [47:0] response,
	output logic               frame_last
);

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_GWIN = 4'd1;
	localparam logic [3:0] ST_BLUR = 4'd2;
	localparam logic [3:0] ST_BWIN = 4'd3;
	localparam logic [3:0] ST_GRAD = 4'd4;
	localparam logic [3:0] ST_DWIN = 4'd5;
	localparam logic [3:0] ST_ACC  = 4'd6;
	localparam logic [3:0] ST_MUL1 = 4'd7;
	localparam logic [3:0] ST_MUL2 = 4'd8;
	localparam logic [3:0] ST_OUT  = 4'd9;

	logic [3:0]        state_q;
	logic [10:0]       width_q, height_q;
	logic [15:0]       k_q;
	logic [46:0]       thresh_q;
	logic              restart_q;
	logic [FILL_W-1:0] fill_q;
	logic [SLOT_W-1:0] slot_q;
	pos_t              pos_q [4];

	logic [WID_W-1:0]  weff;
	logic [ROW_W-1:0]  heff;
	pos_t              init_pos [4];
	pos_t              cur_pos [4];
	logic [FILL_W-1:0] fill_lim;
	logic [SLOT_W-1:0] ns, ra1, ra2;
	logic [SLOT_W:0]   d1, d2;
	logic              acc_in;

	logic              in1_q, in2_q, in3_q, last_q, prod_q;

	pix_t              gray_mem [RING_DEPTH];
	pix_t              blur_mem [RING_DEPTH];
	logic [21:0]       grad_mem [RING_DEPTH];
	pix_t              gray_rd1_q, gray_rd2_q, blur_rd1_q, blur_rd2_q;
	logic [21:0]       grad_rd1_q, grad_rd2_q;

	pix_t              gwin_q [3][3];
	pix_t              bwin_q [3][3];
	logic [21:0]       dwin_q [3][3];

	logic [9:0]        sum3;
	logic [32:0]       gray_prod;
	pix_t              gray_val, gray_q;
	logic [11:0]       sum9;
	logic [32:0]       blur_prod;
	pix_t              blur_q;
	grad_t             gx_c, gy_c, gx_q, gy_q;

	logic [1:0]        arow_q, acol_q;
	logic [21:0]       entry;
	grad_t             ex, ey;
	logic signed [21:0] pxx, pxy, pyy;
	logic [22:0]       a_q, d_q;
	logic signed [23:0] b_q;
	logic [23:0]       s_sum;
	logic [45:0]       ad_q, bb_q, diff_q;
	logic signed [47:0] bsq;
	logic [47:0]       ss_q;
	logic [39:0]       klo_q, khi_q;
	logic [63:0]       kss;
	logic [47:0]       t_val;
	logic signed [48:0] r_val;
	logic              flag_val;
	logic              load;

	logic              out_valid_q, flag_q, last_out_q;
	logic signed [47:0] resp_q;

	always_comb begin
		if (width_q < 11'd3) begin
			weff = WID_W'(3);
		end else if (32'(width_q) > MAX_WIDTH) begin
			weff = WID_W'(MAX_WIDTH);
		end else begin
			weff = WID_W'(width_q);
		end
		heff = (height_q < 11'd3) ? ROW_W'(3) : height_q;
		fill_lim = FILL_W'(3 * (32'(weff) + 1));
	end

	always_comb begin
		logic [ROW_W+1:0] rr;
		rr = '0;
		for (int k = 0; k < 4; k++) begin
			if (k == 0) begin
				init_pos[k] = '0;
			end else begin
				rr = (ROW_W+2)'(heff) - (ROW_W+2)'(k + 1);
				if (rr[ROW_W+1]) begin
					rr = rr + (ROW_W+2)'(heff);
				end
				init_pos[k].row = ROW_W'(rr);
				init_pos[k].col = COL_W'(weff - WID_W'(k));
			end
			cur_pos[k] = restart_q ? init_pos[k] : pos_q[k];
		end
	end

	always_comb begin
		ns = (32'(slot_q) == RING_DEPTH - 1) ? '0 : slot_q + SLOT_W'(1);
		d1 = {1'b0, ns} - (SLOT_W+1)'(weff);
		d2 = {1'b0, ns} - (SLOT_W+1)'({weff, 1'b0});
		if (d1[SLOT_W]) begin
			d1 = d1 + (SLOT_W+1)'(RING_DEPTH);
		end
		if (d2[SLOT_W]) begin
			d2 = d2 + (SLOT_W+1)'(RING_DEPTH);
		end
		ra1 = d1[SLOT_W-1:0];
		ra2 = d2[SLOT_W-1:0];
	end

	assign in_ready = (state_q == ST_IDLE);
	assign acc_in   = in_valid && in_ready;

	always_comb begin
		sum3      = 10'(blue) + 10'(green) + 10'(red);
		gray_prod = 33'(sum3) * 33'(GRAY_MUL);
		gray_val  = action ? '0 : gray_prod[31:24];

		sum9 = '0;
		for (int r = 0; r < 3; r++) begin
			for (int c = 0; c < 3; c++) begin
				sum9 = sum9 + 12'(gwin_q[r][c]);
			end
		end
		blur_prod = 33'(sum9) * 33'(BLUR_MUL);

		gx_c = 11'(bwin_q[0][0]) + 11'(bwin_q[0][1]) + 11'(bwin_q[0][2])
			- 11'(bwin_q[2][0]) - 11'(bwin_q[2][1]) - 11'(bwin_q[2][2]);
		gy_c = 11'(bwin_q[0][0]) + 11'(bwin_q[1][0]) + 11'(bwin_q[2][0])
			- 11'(bwin_q[0][2]) - 11'(bwin_q[1][2]) - 11'(bwin_q[2][2]);

		entry = dwin_q[arow_q][acol_q];
		ex    = entry[21:11];
		ey    = entry[10:0];
		pxx   = ex * ex;
		pxy   = ex * ey;
		pyy   = ey * ey;
		s_sum = {1'b0, a_q} + {1'b0, d_q};
		bsq   = b_q * b_q;

		kss      = {khi_q, 24'b0} + {24'b0, klo_q};
		t_val    = kss[63:16];
		r_val    = $signed({3'b0, diff_q}) - $signed({1'b0, t_val});
		flag_val = r_val > $signed({2'b0, thresh_q});
	end

	assign load = (state_q == ST_OUT) && prod_q && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			width_q     <= 11'd640;
			height_q    <= 11'd480;
			k_q         <= 16'd2621;
			thresh_q    <= 47'd8456501250;
			restart_q   <= 1'b1;
			fill_q      <= '0;
			slot_q      <= '0;
			arow_q      <= '0;
			acol_q      <= '0;
			out_valid_q <= 1'b0;
			for (int k = 0; k < 4; k++) begin
				pos_q[k] <= '0;
			end
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_WIDTH: begin
						width_q   <= cfg_data[10:0];
						restart_q <= 1'b1;
						fill_q    <= '0;
					end
					REG_HEIGHT: begin
						height_q  <= cfg_data[10:0];
						restart_q <= 1'b1;
						fill_q    <= '0;
					end
					REG_K: k_q <= cfg_data[15:0];
					REG_THRESH: thresh_q <= cfg_data;
					default: ;
				endcase
			end
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (acc_in) begin
						slot_q    <= ns;
						restart_q <= 1'b0;
						for (int k = 0; k < 4; k++) begin
							pos_q[k] <= pos_adv(cur_pos[k], weff, heff);
						end
						if (fill_q < fill_lim) begin
							fill_q <= fill_q + FILL_W'(1);
						end
						state_q <= ST_GWIN;
					end
				end
				ST_GWIN: state_q <= ST_BLUR;
				ST_BLUR: state_q <= ST_BWIN;
				ST_BWIN: state_q <= ST_GRAD;
				ST_GRAD: state_q <= ST_DWIN;
				ST_DWIN: begin
					arow_q  <= '0;
					acol_q  <= '0;
					state_q <= ST_ACC;
				end
				ST_ACC: begin
					if (acol_q == 2'd2) begin
						acol_q <= '0;
						arow_q <= arow_q + 2'd1;
						if (arow_q == 2'd2) begin
							state_q <= ST_MUL1;
						end
					end else begin
						acol_q <= acol_q + 2'd1;
					end
				end
				ST_MUL1: state_q <= ST_MUL2;
				ST_MUL2: state_q <= ST_OUT;
				ST_OUT: begin
					if (!prod_q || load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (acc_in) begin
			gray_q     <= gray_val;
			gray_rd1_q <= gray_mem[ra1];
			gray_rd2_q <= gray_mem[ra2];
			blur_rd1_q <= blur_mem[ra1];
			blur_rd2_q <= blur_mem[ra2];
			grad_rd1_q <= grad_mem[ra1];
			grad_rd2_q <= grad_mem[ra2];
			in1_q      <= pos_inner(cur_pos[1], weff, heff);
			in2_q      <= pos_inner(cur_pos[2], weff, heff);
			in3_q      <= pos_inner(cur_pos[3], weff, heff);
			last_q     <= ({1'b0, cur_pos[3].row} + (ROW_W+1)'(1) == {1'b0, heff})
				&& ((WID_W+1)'(cur_pos[3].col) + (WID_W+1)'(1) == {1'b0, weff});
			prod_q     <= (fill_q >= fill_lim);
		end
		if (state_q == ST_GWIN) begin
			gray_mem[slot_q] <= gray_q;
			for (int r = 0; r < 3; r++) begin
				gwin_q[r][2] <= gwin_q[r][1];
				gwin_q[r][1] <= gwin_q[r][0];
			end
			gwin_q[0][0] <= gray_q;
			gwin_q[1][0] <= gray_rd1_q;
			gwin_q[2][0] <= gray_rd2_q;
		end
		if (state_q == ST_BLUR) begin
			blur_q <= in1_q ? blur_prod[31:24] : gwin_q[1][1];
		end
		if (state_q == ST_BWIN) begin
			blur_mem[slot_q] <= blur_q;
			for (int r = 0; r < 3; r++) begin
				bwin_q[r][2] <= bwin_q[r][1];
				bwin_q[r][1] <= bwin_q[r][0];
			end
			bwin_q[0][0] <= blur_q;
			bwin_q[1][0] <= blur_rd1_q;
			bwin_q[2][0] <= blur_rd2_q;
		end
		if (state_q == ST_GRAD) begin
			gx_q <= in2_q ? gx_c : '0;
			gy_q <= in2_q ? gy_c : '0;
		end
		if (state_q == ST_DWIN) begin
			grad_mem[slot_q] <= {gx_q, gy_q};
			for (int r = 0; r < 3; r++) begin
				dwin_q[r][2] <= dwin_q[r][1];
				dwin_q[r][1] <= dwin_q[r][0];
			end
			dwin_q[0][0] <= {gx_q, gy_q};
			dwin_q[1][0] <= grad_rd1_q;
			dwin_q[2][0] <= grad_rd2_q;
			a_q <= '0;
			b_q <= '0;
			d_q <= '0;
		end
		if (state_q == ST_ACC) begin
			a_q <= a_q + {1'b0, pxx};
			b_q <= b_q + {{2{pxy[21]}}, pxy};
			d_q <= d_q + {1'b0, pyy};
		end
		if (state_q == ST_MUL1) begin
			ad_q <= a_q * d_q;
			bb_q <= bsq[45:0];
			ss_q <= s_sum * s_sum;
		end
		if (state_q == ST_MUL2) begin
			klo_q  <= k_q * ss_q[23:0];
			khi_q  <= k_q * ss_q[47:24];
			diff_q <= ad_q - bb_q;
		end
		if (load) begin
			flag_q     <= in3_q && flag_val;
			resp_q     <= in3_q ? r_val[47:0] : '0;
			last_out_q <= last_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign corner_flag = flag_q;
	assign response    = resp_q;
	assign frame_last  = last_out_q;

endmodule

// File: design/hcs_chk.sv
`include "assert_macros.svh"

module hcs_chk (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic               corner_flag,
	input logic signed [47:0] response,
	input logic               frame_last
);

	`ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result beat dropped while stalled")
	`ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "input taken while busy")
	`ASSERT_IMPL(a_flag_positive, out_valid && corner_flag, !response[47] && (response != '0), "flag without positive response")
	`ASSERT_IMPL(a_last_border, out_valid && frame_last, !corner_flag && (response == '0), "frame end pixel not treated as border")

endmodule

bind harris_corner_stream hcs_chk u_hcs_chk (.*);

// File: verif/tb_harris_corner_stream.sv
`timescale 1ns / 1ps

module tb_harris_corner_stream;
	import hcs_pkg::*;

	localparam int          RING         = 2 * MAX_WIDTH + 4;
	localparam int          CYCLE_LIMIT  = 1500000;
	localparam int          SETTLE       = 40;
	localparam longint unsigned THR_MASK = (64'd1 << 47) - 1;

	typedef struct {
		logic        flag;
		logic [47:0] resp;
		logic        last;
	} corner_res_t;

	logic               clk;
	logic               arst_n;
	logic               cfg_we;
	logic [1:0]         cfg_index;
	logic [46:0]        cfg_data;
	logic               in_valid;
	logic               in_ready;
	logic               action;
	logic [7:0]         blue;
	logic [7:0]         green;
	logic [7:0]         red;
	logic               out_valid;
	logic               out_ready;
	logic               corner_flag;
	logic signed [47:0] response;
	logic               frame_last;

	harris_corner_stream uut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.action(action), .blue(blue), .green(green), .red(red),
		.out_valid(out_valid), .out_ready(out_ready),
		.corner_flag(corner_flag), .response(response), .frame_last(frame_last)
	);

	// corner model state
	longint unsigned cur_width, cur_height, cur_k, cur_thr;
	pix_t            gray_mem [RING];
	pix_t            blur_mem [RING];
	int              gx_mem [RING];
	int              gy_mem [RING];
	int unsigned     wr_slot, col_cnt, row_cnt, fill_cnt;

	corner_res_t     corner_q[$];
	int              err_count;
	int              results_seen;
	int              items_sent;
	int              flag_hits;
	int              cycle_count;
	bit              idle_en;
	bit              hold_req;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results pending", cycle_count,
				corner_q.size());
			$display("== FAIL ==");
			$finish;
		end
	end

	task automatic report(string what, longint got, longint want);
		$display("mismatch %s: got %0d expected %0d (result %0d)", what, got, want,
			results_seen);
		err_count++;
	endtask

	function automatic int unsigned eff_w();
		if (cur_width < 3) return 3;
		if (cur_width > MAX_WIDTH) return MAX_WIDTH;
		return int'(cur_width);
	endfunction

	function automatic int unsigned eff_h();
		if (cur_height < 3) return 3;
		return int'(cur_height);
	endfunction

	function automatic int unsigned back(int unsigned lb);
		return (wr_slot + RING - (lb % RING)) % RING;
	endfunction

	function automatic int unsigned nbr(int unsigned w, int dy, int dx);
		return int'(w) + 1 - dy * int'(w) - dx;
	endfunction

	function automatic bit inner_at(int unsigned lag, int unsigned w, int unsigned h,
			output int unsigned q);
		int unsigned total, p, y, x;
		total = w * h;
		p = (row_cnt * w + col_cnt) % total;
		q = (p + total - (lag % total)) % total;
		y = q / w;
		x = q % w;
		return (y >= 1) && (y + 2 <= h) && (x >= 1) && (x + 2 <= w);
	endfunction

	task automatic model_reset();
		cur_width  = 640;
		cur_height = 480;
		cur_k      = 2621;
		cur_thr    = 64'd8456501250;
		for (int i = 0; i < RING; i++) begin
			gray_mem[i] = '0;
			blur_mem[i] = '0;
			gx_mem[i]   = 0;
			gy_mem[i]   = 0;
		end
		wr_slot  = 0;
		col_cnt  = 0;
		row_cnt  = 0;
		fill_cnt = 0;
	endtask

	task automatic predict_corner(logic act, pix_t b, pix_t g, pix_t r);
		int unsigned     w, h, base, q, gray, sum;
		int              gx, gy;
		longint          a, bb, d, resp;
		longint unsigned s, t;
		corner_res_t     res;
		w = eff_w();
		h = eff_h();
		base = w + 1;
		gray = 0;
		if (!act)
			gray = (int'(b) + int'(g) + int'(r)) * 3333 / 10000;
		wr_slot = (wr_slot + 1) % RING;
		gray_mem[wr_slot] = gray[7:0];

		if (inner_at(base, w, h, q)) begin
			sum = 0;
			for (int dy = -1; dy <= 1; dy++)
				for (int dx = -1; dx <= 1; dx++)
					sum += gray_mem[back(nbr(w, dy, dx))];
			sum = sum * 111 / 1000;
			blur_mem[wr_slot] = sum[7:0];
		end else begin
			blur_mem[wr_slot] = gray_mem[back(base)];
		end

		gx = 0;
		gy = 0;
		if (inner_at(2 * base, w, h, q)) begin
			for (int dx = -1; dx <= 1; dx++)
				gx += int'(blur_mem[back(nbr(w, 1, dx))])
					- int'(blur_mem[back(nbr(w, -1, dx))]);
			for (int dy = -1; dy <= 1; dy++)
				gy += int'(blur_mem[back(nbr(w, dy, 1))])
					- int'(blur_mem[back(nbr(w, dy, -1))]);
		end
		gx_mem[wr_slot] = gx;
		gy_mem[wr_slot] = gy;

		if (fill_cnt >= 3 * base) begin
			resp = 0;
			res.flag = 1'b0;
			if (inner_at(3 * base, w, h, q)) begin
				a = 0;
				bb = 0;
				d = 0;
				for (int dy = -1; dy <= 1; dy++)
					for (int dx = -1; dx <= 1; dx++) begin
						longint vx, vy;
						vx = gx_mem[back(nbr(w, dy, dx))];
						vy = gy_mem[back(nbr(w, dy, dx))];
						a += vx * vx;
						bb += vx * vy;
						d += vy * vy;
					end
				s = longint'(a + d);
				t = (cur_k * s * s) >> 16;
				resp = a * d - bb * bb - longint'(t);
				res.flag = resp > longint'(cur_thr);
			end
			res.resp = resp[47:0];
			res.last = (q == w * h - 1);
			corner_q.push_back(res);
		end else begin
			fill_cnt++;
		end

		col_cnt++;
		if (col_cnt >= w) begin
			col_cnt = 0;
			row_cnt++;
			if (row_cnt >= h) row_cnt = 0;
		end
	endtask

	task automatic write_reg(logic [1:0] idx, longint unsigned value);
		@(negedge clk);
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_data  = value[46:0];
		@(negedge clk);
		cfg_we = 1'b0;
		case (idx)
			REG_WIDTH:  begin cur_width = value & 64'h7FF; col_cnt = 0; row_cnt = 0; fill_cnt = 0; end
			REG_HEIGHT: begin cur_height = value & 64'h7FF; col_cnt = 0; row_cnt = 0; fill_cnt = 0; end
			REG_K:      cur_k = value & 64'hFFFF;
			REG_THRESH: cur_thr = value & THR_MASK;
			default: ;
		endcase
	endtask

	task automatic setup(longint unsigned w, longint unsigned h, longint unsigned k,
			longint unsigned thr);
		write_reg(REG_WIDTH, w);
		write_reg(REG_HEIGHT, h);
		write_reg(REG_K, k);
		write_reg(REG_THRESH, thr);
	endtask

	task automatic send_item(logic act, pix_t b, pix_t g, pix_t r);
		int gap;
		@(negedge clk);
		in_valid = 1'b1;
		action   = act;
		blue     = b;
		green    = g;
		red      = r;
		do @(posedge clk); while (!in_ready);
		predict_corner(act, b, g, r);
		items_sent++;
		gap = 0;
		if (idle_en && $urandom_range(0, 3) == 0)
			gap = $urandom_range(1, 8);
		if (gap > 0) begin
			@(negedge clk);
			in_valid = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	task automatic drain();
		@(negedge clk);
		in_valid = 1'b0;
		while (corner_q.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	function automatic pix_t pick_byte();
		case ($urandom_range(0, 3))
			0: return 8'd0;
			1: return 8'd255;
			default: return pix_t'($urandom);
		endcase
	endfunction

	task automatic send_random(int n, int flush_pct);
		for (int i = 0; i < n; i++)
			send_item($urandom_range(0, 99) < flush_pct, pick_byte(), pick_byte(), pick_byte());
	endtask

	// result checker
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			corner_res_t want;
			results_seen++;
			if (corner_q.size() == 0) begin
				$display("unexpected result beat %0d", results_seen);
				err_count++;
			end else begin
				want = corner_q.pop_front();
				if (corner_flag !== want.flag) report("corner_flag", corner_flag, want.flag);
				if (response !== want.resp)
					report("response", response, longint'(signed'(want.resp)));
				if (frame_last !== want.last) report("frame_last", frame_last, want.last);
				if (want.flag) flag_hits++;
			end
		end
	end

	// receiver
	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				out_ready = 1'b0;
				repeat (400) @(negedge clk);
				hold_req  = 1'b0;
				out_ready = 1'b1;
			end else if (idle_en && $urandom_range(0, 5) == 0) begin
				out_ready = 1'b0;
				repeat ($urandom_range(0, 7)) @(negedge clk);
			end else begin
				out_ready = 1'b1;
			end
		end
	end

	task automatic test_directed();
		setup(5, 4, 2621, 1000);
		for (int i = 0; i < 40; i++) begin
			case (i % 8)
				0: send_item(1'b0, 8'd255, 8'd255, 8'd255);
				1: send_item(1'b0, 8'd0, 8'd0, 8'd0);
				2: send_item(1'b0, 8'd255, 8'd0, 8'd0);
				3: send_item(1'b0, 8'd0, 8'd255, 8'd0);
				4: send_item(1'b0, 8'd0, 8'd0, 8'd255);
				5: send_item(1'b1, 8'd255, 8'd255, 8'd255);
				6: send_item(1'b0, 8'd255, 8'd255, 8'd255);
				default: send_item(1'b1, 8'd0, 8'd0, 8'd0);
			endcase
		end
		drain();
	endtask

	task automatic test_saturation();
		setup(0, 0, 0, 0);
		send_random(40, 10);
		drain();
		setup(3, 3, 65535, THR_MASK);
		send_random(40, 10);
		drain();
	endtask

	task automatic test_random();
		longint unsigned thr;
		for (int ph = 0; ph < 5; ph++) begin
			case ($urandom_range(0, 2))
				0: thr = 0;
				1: thr = $urandom_range(0, 1 << 20);
				default: thr = {$urandom, $urandom} & THR_MASK;
			endcase
			setup($urandom_range(3, 8), $urandom_range(3, 8),
				(ph == 0) ? 65535 : $urandom_range(0, 65535), thr);
			send_random($urandom_range(30, 60), 12);
			drain();
		end
	endtask

	task automatic test_backpressure();
		setup(4, 5, 2621, 5000);
		send_random(30, 0);
		@(negedge clk);
		hold_req = 1'b1;
		send_random(40, 10);
		drain();
	endtask

	task automatic test_wide();
		setup(64, 3, 2621, 500);
		for (int i = 0; i < 3 * 65 + 20; i++) begin
			if (i % 37 == 0) send_item(1'b0, pick_byte(), pick_byte(), pick_byte());
			else send_item(1'b1, 8'd0, 8'd0, 8'd0);
		end
		drain();
	endtask

	initial begin
		arst_n      = 1'b0;
		cfg_we      = 1'b0;
		cfg_index   = REG_WIDTH;
		cfg_data    = '0;
		in_valid    = 1'b0;
		action      = 1'b0;
		blue        = '0;
		green       = '0;
		red         = '0;
		err_count   = 0;
		results_seen = 0;
		items_sent  = 0;
		flag_hits   = 0;
		cycle_count = 0;
		idle_en     = 1'b1;
		hold_req    = 1'b0;
		model_reset();
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		repeat (SETTLE) @(posedge clk);

		test_directed();
		test_saturation();
		test_backpressure();
		test_random();
		idle_en = 1'b0;
		setup(6, 5, 1000, 2000);
		send_random(80, 10);
		drain();
		test_wide();

		$display("sent %0d items over widths 3 to 64, checked %0d results, %0d flagged",
			items_sent, results_seen, flag_hits);
		if (err_count == 0) begin
			$display("== PASS ==");
		end else begin
			$display("%0d mismatches", err_count);
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
